>>> design/mfv_pkg.sv
// ----------------------------------------------------------------------------
// mfv_pkg: shared types and constants for the most/least frequent value block
// Holds the default sizes, the fixed field widths of the ports and the
// sequencer state type.
// ----------------------------------------------------------------------------
package mfv_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MAX_ITEMS_DEF   = 1024;
    localparam int VALUE_BITS_DEF  = 32;

    // Fixed port field widths
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    // Largest count the result fields can carry
    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

>>> design/mfv_table.sv
// ----------------------------------------------------------------------------
// mfv_table: distinct-value table storage
// One write port and one read port; read data is registered, so it shows up
// the cycle after the address.
// ----------------------------------------------------------------------------
module mfv_table #(
    parameter int DEPTH    = mfv_pkg::TABLE_DEPTH_DEF,
    parameter int VAL_W    = mfv_pkg::VALUE_BITS_DEF,
    parameter int CNT_W    = mfv_pkg::COUNT_W
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [VAL_W-1:0]         i_wr_value,
    input  logic [CNT_W-1:0]         i_wr_count,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [VAL_W-1:0]         o_rd_value,
    output logic [CNT_W-1:0]         o_rd_count
);

    logic [VAL_W-1:0] r_mem_value [DEPTH];
    logic [CNT_W-1:0] r_mem_count [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_value[i_wr_addr] <= i_wr_value;
            r_mem_count[i_wr_addr] <= i_wr_count;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_value <= r_mem_value[i_rd_addr];
        o_rd_count <= r_mem_count[i_rd_addr];
    end

endmodule

>>> design/most_and_least_frequent_value.sv
// ----------------------------------------------------------------------------
// most_and_least_frequent_value: mode and least frequent element of a set
// Builds a table of distinct values with counts over a set of beats and,
// after the beat marked final, reports the most and least frequent values.
// ----------------------------------------------------------------------------
// Each input beat is searched against the distinct-value table one entry per
// cycle through the table's single read port, until it matches an entry or
// has passed all distinct values held so far (at most TABLE_DEPTH); a new
// value is then appended. A beat marked final_item then sweeps the whole
// table again and the result register is loaded after the sweep; the input
// is stalled for all of that. The result waits in its own register, so the
// next set may start while it is stalled. Ties go to the value seen first.
// Counts saturate at MAX_ITEMS, beats past MAX_ITEMS or new values past a
// full table are dropped, and either case sets overflow_flag for the set.
// The table needs no clearing after reset.
module most_and_least_frequent_value #(
    parameter int TABLE_DEPTH = mfv_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_ITEMS   = mfv_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS  = mfv_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [mfv_pkg::DATA_W-1:0] i_sample_value,
    input  logic                              i_final_item,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [mfv_pkg::DATA_W-1:0] o_most_value,
    output logic [mfv_pkg::COUNT_W-1:0]       o_most_count,
    output logic signed [mfv_pkg::DATA_W-1:0] o_least_value,
    output logic [mfv_pkg::COUNT_W-1:0]       o_least_count,
    output logic                              o_overflow_flag
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int IW     = $clog2(TABLE_DEPTH + 1);
    localparam int CW     = $clog2(MAX_ITEMS + 1);
    localparam int IN_W   = (VALUE_BITS < mfv_pkg::DATA_W) ? VALUE_BITS : mfv_pkg::DATA_W;

    // Sequencer and control state
    mfv_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_rd_valid, n_rd_valid;
    logic [IW-1:0]   r_used, n_used;
    logic [CW-1:0]   r_items, n_items;
    logic            r_ovf, n_ovf;
    logic            r_have, n_have;
    logic            r_out_valid, n_out_valid;

    // Payload state
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic                  r_final, n_final;
    logic [AW-1:0]         r_rd_idx, n_rd_idx;
    logic [VALUE_BITS-1:0] r_most_v, n_most_v, r_least_v, n_least_v;
    logic [CW-1:0]         r_most_c, n_most_c, r_least_c, n_least_c;
    logic [mfv_pkg::DATA_W-1:0]  r_o_most_v, n_o_most_v, r_o_least_v, n_o_least_v;
    logic [mfv_pkg::COUNT_W-1:0] r_o_most_c, n_o_most_c, r_o_least_c, n_o_least_c;
    logic                        r_o_ovf, n_o_ovf;

    // Table ports
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [VALUE_BITS-1:0] w_wr_value;
    logic [CW-1:0]         w_wr_count;
    logic [VALUE_BITS-1:0] w_rd_value;
    logic [CW-1:0]         w_rd_count;

    // Decoded conditions
    logic                  w_in_accept;
    logic [VALUE_BITS-1:0] w_in_value;
    logic                  w_items_full;
    logic                  w_rd_done;
    logic                  w_match;
    logic                  w_search_end;
    logic                  w_scan_end;
    logic                  w_emit;

    mfv_table #(
        .DEPTH (TABLE_DEPTH),
        .VAL_W (VALUE_BITS),
        .CNT_W (CW)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_value (w_wr_value),
        .i_wr_count (w_wr_count),
        .i_rd_addr  (r_idx[AW-1:0]),
        .o_rd_value (w_rd_value),
        .o_rd_count (w_rd_count)
    );

    // Handshake and compare conditions
    assign o_in_stall   = (r_state != mfv_pkg::ST_IDLE);
    assign w_in_accept  = i_in_valid && !o_in_stall;
    assign w_in_value   = VALUE_BITS'(i_sample_value[IN_W-1:0]);
    assign w_items_full = (32'(r_items) >= 32'(MAX_ITEMS));
    assign w_rd_done    = (r_idx == r_used);
    assign w_match      = r_rd_valid && (w_rd_value == r_value);
    assign w_search_end = w_match || (!r_rd_valid && w_rd_done);
    assign w_scan_end   = !r_rd_valid && w_rd_done;
    assign w_emit       = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mfv_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    if (!w_items_full) begin
                        n_state = mfv_pkg::ST_SEARCH;
                    end else if (i_final_item) begin
                        n_state = mfv_pkg::ST_SCAN;
                    end
                end
            end
            mfv_pkg::ST_SEARCH: begin
                if (w_search_end) begin
                    n_state = r_final ? mfv_pkg::ST_SCAN : mfv_pkg::ST_IDLE;
                end
            end
            mfv_pkg::ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = mfv_pkg::ST_EMIT;
                end
            end
            mfv_pkg::ST_EMIT: begin
                if (w_emit) begin
                    n_state = mfv_pkg::ST_IDLE;
                end
            end
            default: n_state = mfv_pkg::ST_IDLE;
        endcase
    end

    // Datapath and table access
    always_comb begin
        n_idx       = r_idx;
        n_rd_valid  = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_used      = r_used;
        n_items     = r_items;
        n_ovf       = r_ovf;
        n_have      = r_have;
        n_value     = r_value;
        n_final     = r_final;
        n_most_v    = r_most_v;
        n_most_c    = r_most_c;
        n_least_v   = r_least_v;
        n_least_c   = r_least_c;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_most_v  = r_o_most_v;
        n_o_most_c  = r_o_most_c;
        n_o_least_v = r_o_least_v;
        n_o_least_c = r_o_least_c;
        n_o_ovf     = r_o_ovf;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_rd_idx;
        w_wr_value  = r_value;
        w_wr_count  = w_rd_count;

        unique case (r_state)
            // take a beat, drop it if the item budget is spent
            mfv_pkg::ST_IDLE: begin
                n_idx  = '0;
                n_have = 1'b0;
                if (w_in_accept) begin
                    n_value = w_in_value;
                    n_final = i_final_item;
                    if (w_items_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_items = r_items + 1'b1;
                    end
                end
            end

            // one read issued and one entry compared per cycle
            mfv_pkg::ST_SEARCH: begin
                if (w_match) begin
                    if (32'(w_rd_count) < 32'(MAX_ITEMS)) begin
                        w_wr_en    = 1'b1;
                        w_wr_count = w_rd_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_idx = '0;
                end else if (!r_rd_valid && w_rd_done) begin
                    // not found: append or flag a full table
                    if (r_used < IW'(TABLE_DEPTH)) begin
                        w_wr_en    = 1'b1;
                        w_wr_addr  = r_used[AW-1:0];
                        w_wr_count = CW'(1);
                        n_used     = r_used + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_idx = '0;
                end else if (!w_rd_done) begin
                    n_idx      = r_idx + 1'b1;
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_idx[AW-1:0];
                end
            end

            // sweep the table for the largest and smallest counts
            mfv_pkg::ST_SCAN: begin
                if (r_rd_valid) begin
                    n_have = 1'b1;
                    if (!r_have) begin
                        n_most_v  = w_rd_value;
                        n_most_c  = w_rd_count;
                        n_least_v = w_rd_value;
                        n_least_c = w_rd_count;
                    end else begin
                        if (w_rd_count > r_most_c) begin
                            n_most_v = w_rd_value;
                            n_most_c = w_rd_count;
                        end
                        if (w_rd_count < r_least_c) begin
                            n_least_v = w_rd_value;
                            n_least_c = w_rd_count;
                        end
                    end
                end
                if (!w_rd_done) begin
                    n_idx      = r_idx + 1'b1;
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_idx[AW-1:0];
                end else if (!r_rd_valid) begin
                    n_idx = '0;
                end
            end

            // load the result beat and start a fresh set
            mfv_pkg::ST_EMIT: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    n_o_ovf     = r_ovf;
                    if (r_have) begin
                        n_o_most_v  = mfv_pkg::DATA_W'(r_most_v);
                        n_o_least_v = mfv_pkg::DATA_W'(r_least_v);
                        n_o_most_c  = (32'(r_most_c) > 32'(mfv_pkg::COUNT_SAT)) ?
                                      mfv_pkg::COUNT_SAT : mfv_pkg::COUNT_W'(r_most_c);
                        n_o_least_c = (32'(r_least_c) > 32'(mfv_pkg::COUNT_SAT)) ?
                                      mfv_pkg::COUNT_SAT : mfv_pkg::COUNT_W'(r_least_c);
                    end else begin
                        n_o_most_v  = '0;
                        n_o_least_v = '0;
                        n_o_most_c  = '0;
                        n_o_least_c = '0;
                    end
                    n_used  = '0;
                    n_items = '0;
                    n_ovf   = 1'b0;
                end
            end

            default: begin
                n_idx = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfv_pkg::ST_IDLE;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_used      <= '0;
            r_items     <= '0;
            r_ovf       <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rd_valid  <= n_rd_valid;
            r_used      <= n_used;
            r_items     <= n_items;
            r_ovf       <= n_ovf;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_final     <= n_final;
        r_rd_idx    <= n_rd_idx;
        r_most_v    <= n_most_v;
        r_most_c    <= n_most_c;
        r_least_v   <= n_least_v;
        r_least_c   <= n_least_c;
        r_o_most_v  <= n_o_most_v;
        r_o_most_c  <= n_o_most_c;
        r_o_least_v <= n_o_least_v;
        r_o_least_c <= n_o_least_c;
        r_o_ovf     <= n_o_ovf;
    end

    // Result beat
    assign o_out_valid     = r_out_valid;
    assign o_most_value    = r_o_most_v;
    assign o_most_count    = r_o_most_c;
    assign o_least_value   = r_o_least_v;
    assign o_least_count   = r_o_least_c;
    assign o_overflow_flag = r_o_ovf;

endmodule
